@@ src/spf_pkg.sv @@
`default_nettype none
package spf_pkg;

  // SLIP framing codes
  localparam logic [7:0] FEND     = 8'hC0;
  localparam logic [7:0] FESC     = 8'hDB;
  localparam logic [7:0] FESC_END = 8'hDC;
  localparam logic [7:0] FESC_ESC = 8'hDD;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  // Input command codes
  localparam logic CMD_HEADER  = 1'b0;
  localparam logic CMD_PAYLOAD = 1'b1;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTRW  = $clog2(QDEPTH);
  localparam int unsigned QCNTW  = $clog2(QDEPTH + 1);

  // One queued job: a header (four bytes) or a payload byte (byte 0)
  typedef struct packed {
    logic            is_hdr;
    logic            close;
    logic [3:0][7:0] hb;
  } spf_entry_t;

  // Reflected CRC-16 nibble table, polynomial 0x8408
  function automatic logic [15:0] nib_tab(input logic [3:0] n);
    logic [15:0] t;
    case (n)
      4'h0:    t = 16'h0000;
      4'h1:    t = 16'h1081;
      4'h2:    t = 16'h2102;
      4'h3:    t = 16'h3183;
      4'h4:    t = 16'h4204;
      4'h5:    t = 16'h5285;
      4'h6:    t = 16'h6306;
      4'h7:    t = 16'h7387;
      4'h8:    t = 16'h8408;
      4'h9:    t = 16'h9489;
      4'hA:    t = 16'ha50a;
      4'hB:    t = 16'hb58b;
      4'hC:    t = 16'hc60c;
      4'hD:    t = 16'hd68d;
      4'hE:    t = 16'he70e;
      default: t = 16'hf78f;
    endcase
    return t;
  endfunction

  // Fold one byte into the running CRC, low nibble first
  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] c1;
    logic [15:0] c2;
    c1 = {4'h0, c[15:4]} ^ nib_tab(c[3:0] ^ b[3:0]);
    c2 = {4'h0, c1[15:4]} ^ nib_tab(c1[3:0] ^ b[7:4]);
    return c2;
  endfunction

  function automatic logic [15:0] bit_rev16(input logic [15:0] c);
    logic [15:0] r;
    for (int i = 0; i < 16; i++) begin
      r[i] = c[15 - i];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ src/slip_packet_framer_crc16_top.sv @@
`default_nettype none
// Channel   Handshake            Payload
// in        in_valid/in_ready    command, header fields, data byte
// out       out_valid/out_ready  out_byte, frame_end, last_of_run
// cfg       cfg_we               cfg_wdata (crc_enable)
//
// One line byte leaves the serializer per cycle while out_ready holds: a header item
// gives 5 to 14 line bytes, a payload item 1 or 2, plus up to 5 when it closes the frame.
// The front takes one item per cycle while the two-entry queue has room.
// Reset is synchronous and active low; crc_enable clears to 0.
// Output stalls hold the output register and back up through the queue.
module slip_packet_framer_crc16_top
  import spf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_command,
  input  wire logic [2:0]  in_seq_num,
  input  wire logic [2:0]  in_ack_num,
  input  wire logic        in_crc_flag,
  input  wire logic        in_reliable,
  input  wire logic [3:0]  in_protocol_id,
  input  wire logic [11:0] in_payload_len,
  input  wire logic [7:0]  in_data_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_byte,
  output logic             out_frame_end,
  output logic             out_last_of_run
);

  logic       crc_en_r;
  logic       q_full, q_push, q_pop, q_valid;
  spf_entry_t q_wdata, q_head;

  // Hold the CRC enable register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_en_r <= 1'b0;
    end else if (cfg_we) begin
      crc_en_r <= cfg_wdata;
    end
  end

  spf_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .crc_en         (crc_en_r),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_command     (in_command),
    .in_seq_num     (in_seq_num),
    .in_ack_num     (in_ack_num),
    .in_crc_flag    (in_crc_flag),
    .in_reliable    (in_reliable),
    .in_protocol_id (in_protocol_id),
    .in_payload_len (in_payload_len),
    .in_data_byte   (in_data_byte),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_data         (q_wdata)
  );

  spf_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_wdata),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  spf_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .crc_en          (crc_en_r),
    .head_valid      (q_valid),
    .head            (q_head),
    .pop             (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_frame_end   (out_frame_end),
    .out_last_of_run (out_last_of_run)
  );

endmodule
`default_nettype wire

@@ src/spf_front.sv @@
`default_nettype none
module spf_front
  import spf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        crc_en,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_command,
  input  wire logic [2:0]  in_seq_num,
  input  wire logic [2:0]  in_ack_num,
  input  wire logic        in_crc_flag,
  input  wire logic        in_reliable,
  input  wire logic [3:0]  in_protocol_id,
  input  wire logic [11:0] in_payload_len,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        q_full,
  output logic             q_push,
  output spf_entry_t       q_data
);

  logic        frame_open_r, frame_open_nxt;
  logic [11:0] bytes_left_r, bytes_left_nxt;
  logic [11:0] left_dec;
  logic [7:0]  h0, h1, h2, h3;
  logic        take;

  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;
  assign left_dec = bytes_left_r - 12'd1;

  // Build the header bytes and their check byte
  always_comb begin
    h0 = {in_reliable, in_crc_flag | crc_en, in_ack_num, in_seq_num};
    h1 = {in_payload_len[3:0], in_protocol_id};
    h2 = in_payload_len[11:4];
    h3 = 8'hFF - (h0 + h1 + h2);
  end

  // Classify the item and track frame progress
  always_comb begin
    frame_open_nxt = frame_open_r;
    bytes_left_nxt = bytes_left_r;
    q_push         = 1'b0;
    q_data.is_hdr  = 1'b0;
    q_data.close   = 1'b0;
    q_data.hb      = {h3, h2, h1, h0};
    if (in_command == CMD_HEADER) begin
      q_data.is_hdr = 1'b1;
      q_data.close  = (in_payload_len == 12'd0);
      if (take) begin
        q_push         = 1'b1;
        frame_open_nxt = (in_payload_len != 12'd0);
        bytes_left_nxt = in_payload_len;
      end
    end else begin
      q_data.hb    = {24'h000000, in_data_byte};
      q_data.close = (left_dec == 12'd0);
      // drop payload with no open frame
      if (take && frame_open_r) begin
        q_push         = 1'b1;
        bytes_left_nxt = left_dec;
        if (left_dec == 12'd0) begin
          frame_open_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_open_r <= 1'b0;
      bytes_left_r <= 12'd0;
    end else begin
      frame_open_r <= frame_open_nxt;
      bytes_left_r <= bytes_left_nxt;
    end
  end

endmodule
`default_nettype wire

@@ src/spf_fifo.sv @@
`default_nettype none
module spf_fifo
  import spf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire spf_entry_t push_data,
  output logic            full,
  input  wire logic       pop,
  output logic            head_valid,
  output spf_entry_t      head
);

  spf_entry_t             store_r [QDEPTH];
  logic [QPTRW-1:0]       wr_ptr_r, rd_ptr_r;
  logic [QCNTW-1:0]       count_r;

  assign full       = (count_r == QCNTW'(QDEPTH));
  assign head_valid = (count_r != '0);
  assign head       = store_r[rd_ptr_r];

  // Write the entry at the tail
  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= push_data;
    end
  end

  // Advance pointers and hold the fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTRW'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTRW'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ src/spf_back.sv @@
`default_nettype none
module spf_back
  import spf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       crc_en,
  input  wire logic       head_valid,
  input  wire spf_entry_t head,
  output logic            pop,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            out_frame_end,
  output logic            out_last_of_run
);

  typedef enum logic [2:0] {
    PH_NEW,
    PH_SOF,
    PH_DATA,
    PH_CRC_HI,
    PH_CRC_LO,
    PH_EOF
  } phase_t;

  phase_t      ph_r, ph_nxt, eff_ph;
  logic [1:0]  idx_r, idx_nxt;
  logic        esc_r, esc_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [15:0] crc_rev;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_byte_r, out_byte_nxt;
  logic        frame_end_r, frame_end_nxt;
  logic        last_r, last_nxt;
  logic [7:0]  raw, line_byte;
  logic        plain, special, done, fire, last_data;

  assign crc_rev   = bit_rev16(crc_r);
  assign fire      = head_valid && (!out_valid_r || out_ready);
  assign last_data = !head.is_hdr || (idx_r == 2'd3);

  always_comb begin
    if (ph_r == PH_NEW) begin
      eff_ph = head.is_hdr ? PH_SOF : PH_DATA;
    end else begin
      eff_ph = ph_r;
    end
  end

  // Select the raw byte for the current step
  always_comb begin
    plain = 1'b0;
    case (eff_ph)
      PH_SOF: begin
        raw   = FEND;
        plain = 1'b1;
      end
      PH_DATA:   raw = head.is_hdr ? head.hb[idx_r] : head.hb[0];
      PH_CRC_HI: raw = crc_rev[15:8];
      PH_CRC_LO: raw = crc_rev[7:0];
      PH_EOF: begin
        raw   = FEND;
        plain = 1'b1;
      end
      default: begin
        raw   = FEND;
        plain = 1'b1;
      end
    endcase
  end

  // Escape: delimiter and escape codes go out as two bytes
  always_comb begin
    special = !plain && ((raw == FEND) || (raw == FESC));
    if (special && !esc_r) begin
      line_byte = FESC;
      done      = 1'b0;
    end else if (special) begin
      line_byte = (raw == FEND) ? FESC_END : FESC_ESC;
      done      = 1'b1;
    end else begin
      line_byte = raw;
      done      = 1'b1;
    end
  end

  // Step the sequencer and load the output register
  always_comb begin
    ph_nxt        = ph_r;
    idx_nxt       = idx_r;
    esc_nxt       = esc_r;
    crc_nxt       = crc_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_byte_nxt  = out_byte_r;
    frame_end_nxt = frame_end_r;
    last_nxt      = last_r;
    pop           = 1'b0;
    if (fire) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = line_byte;
      frame_end_nxt = (eff_ph == PH_EOF);
      esc_nxt       = special && !esc_r;
      case (eff_ph)
        PH_SOF: begin
          crc_nxt = CRC_INIT;
          idx_nxt = 2'd0;
          ph_nxt  = PH_DATA;
        end
        PH_DATA: begin
          if (done) begin
            crc_nxt = crc_byte(crc_r, raw);
            if (!last_data) begin
              idx_nxt = idx_r + 2'd1;
              ph_nxt  = PH_DATA;
            end else if (head.close) begin
              ph_nxt = crc_en ? PH_CRC_HI : PH_EOF;
            end else begin
              pop    = 1'b1;
              ph_nxt = PH_NEW;
            end
          end else begin
            ph_nxt = PH_DATA;
          end
        end
        PH_CRC_HI: ph_nxt = done ? PH_CRC_LO : PH_CRC_HI;
        PH_CRC_LO: ph_nxt = done ? PH_EOF : PH_CRC_LO;
        PH_EOF: begin
          pop    = 1'b1;
          ph_nxt = PH_NEW;
        end
        default: ph_nxt = PH_NEW;
      endcase
      last_nxt = pop;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r        <= PH_NEW;
      idx_r       <= 2'd0;
      esc_r       <= 1'b0;
      crc_r       <= CRC_INIT;
      out_valid_r <= 1'b0;
    end else begin
      ph_r        <= ph_nxt;
      idx_r       <= idx_nxt;
      esc_r       <= esc_nxt;
      crc_r       <= crc_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_byte_r  <= out_byte_nxt;
    frame_end_r <= frame_end_nxt;
    last_r      <= last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_frame_end   = frame_end_r;
  assign out_last_of_run = last_r;

endmodule
`default_nettype wire

@@ tb/sv/slip_packet_framer_crc16_top_tb.sv @@
`timescale 1ns / 100ps
module slip_packet_framer_crc16_top_tb;
  import spf_pkg::*;

  localparam int          CYCLE_LIMIT     = 400000;
  localparam int          SETTLE_CYCLES   = 40;
  localparam int          ITEMS_PER_PHASE = 140;
  localparam int          MAX_SHOWN       = 10;
  localparam logic [15:0] CRC_POLY_REF    = 16'h8408;

  typedef struct packed {
    logic        cmd;
    logic [2:0]  seq;
    logic [2:0]  ack;
    logic        crcf;
    logic        rel;
    logic [3:0]  pid;
    logic [11:0] len;
    logic [7:0]  data;
  } link_item_t;

  typedef struct packed {
    logic [7:0] b;
    logic       fe;
    logic       last;
  } line_byte_t;

  // One step of the directed plan: a register write or an input item,
  // the latter optionally with its line bytes written out by hand
  typedef struct packed {
    logic            is_cfg;
    logic            cfg_val;
    link_item_t      it;
    logic            typed;
    logic [2:0]      tn;
    logic [0:5][7:0] tb;
    logic            tclose;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_wdata = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_command = 1'b0;
  logic [2:0]  in_seq_num = '0;
  logic [2:0]  in_ack_num = '0;
  logic        in_crc_flag = 1'b0;
  logic        in_reliable = 1'b0;
  logic [3:0]  in_protocol_id = '0;
  logic [11:0] in_payload_len = '0;
  logic [7:0]  in_data_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic        out_frame_end;
  logic        out_last_of_run;

  // Framer state as predicted
  logic        crc_en_m = 1'b0;
  logic [11:0] left_m = '0;
  logic        open_m = 1'b0;
  logic [15:0] crc_m = CRC_INIT;

  line_byte_t  burst_q[$];   // line bytes caused by the current item
  line_byte_t  line_q[$];    // line bytes still owed by the block
  dir_row_t    plan_q[$];

  int snd_idle = 0;
  int rcv_idle = 0;
  int errors = 0;
  int cycles = 0;
  int n_items = 0;
  int n_ignored = 0;
  int n_bytes = 0;
  int n_cfg = 0;

  slip_packet_framer_crc16_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_command      (in_command),
    .in_seq_num      (in_seq_num),
    .in_ack_num      (in_ack_num),
    .in_crc_flag     (in_crc_flag),
    .in_reliable     (in_reliable),
    .in_protocol_id  (in_protocol_id),
    .in_payload_len  (in_payload_len),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_frame_end   (out_frame_end),
    .out_last_of_run (out_last_of_run)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Guard against a hung handshake
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d line bytes outstanding", cycles, line_q.size());
      $display("slip_packet_framer_crc16_top test failed");
      $finish;
    end
  end

  // Receiver back-pressure
  always @(negedge clk) begin
    out_ready = ($urandom_range(0, 99) >= rcv_idle);
  end

  function automatic void note_fault(input string msg);
    errors++;
    if (errors <= MAX_SHOWN) $display("MISMATCH: %s", msg);
  endfunction

  // Check each line byte transfer against the oldest owed byte
  always @(posedge clk) begin
    line_byte_t want;
    if (rst_n && out_valid && out_ready) begin
      n_bytes++;
      if (line_q.size() == 0) begin
        note_fault($sformatf("unowed line byte %h end %b last %b",
                             out_byte, out_frame_end, out_last_of_run));
      end else begin
        want = line_q.pop_front();
        if (out_byte !== want.b || out_frame_end !== want.fe || out_last_of_run !== want.last)
          note_fault($sformatf("line byte %0d: got %h end %b last %b, want %h end %b last %b",
                               n_bytes, out_byte, out_frame_end, out_last_of_run,
                               want.b, want.fe, want.last));
      end
    end
  end

  // Reflected CRC-16, one bit at a time
  function automatic logic [15:0] crc_fold(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] acc;
    int          i;
    acc = c;
    for (i = 0; i < 8; i++)
      acc = (acc[0] ^ b[i]) ? ((acc >> 1) ^ CRC_POLY_REF) : (acc >> 1);
    return acc;
  endfunction

  function automatic logic [15:0] mirror16(input logic [15:0] c);
    logic [15:0] r;
    int          i;
    for (i = 0; i < 16; i++) r[i] = c[15 - i];
    return r;
  endfunction

  function automatic void put_raw(input logic [7:0] b, input logic fe);
    line_byte_t lb;
    lb.b    = b;
    lb.fe   = fe;
    lb.last = 1'b0;
    burst_q.push_back(lb);
  endfunction

  // SLIP escaping of one frame byte
  function automatic void put_esc(input logic [7:0] b);
    if (b == FEND) begin
      put_raw(FESC, 1'b0);
      put_raw(FESC_END, 1'b0);
    end else if (b == FESC) begin
      put_raw(FESC, 1'b0);
      put_raw(FESC_ESC, 1'b0);
    end else begin
      put_raw(b, 1'b0);
    end
  endfunction

  function automatic void put_data(input logic [7:0] b);
    crc_m = crc_fold(crc_m, b);
    put_esc(b);
  endfunction

  // Trailer follows the register as it stands when the frame closes
  function automatic void put_close();
    logic [15:0] r;
    if (crc_en_m) begin
      r = mirror16(crc_m);
      put_esc(r[15:8]);
      put_esc(r[7:0]);
    end
    put_raw(FEND, 1'b1);
    open_m = 1'b0;
    left_m = '0;
  endfunction

  // Work out the line bytes that one input item causes
  function automatic void frame_item(input link_item_t it);
    logic [7:0] h0;
    logic [7:0] h1;
    logic [7:0] h2;
    logic [7:0] h3;
    burst_q.delete();
    if (it.cmd == CMD_HEADER) begin
      h0 = {it.rel, it.crcf | crc_en_m, it.ack, it.seq};
      h1 = {it.len[3:0], it.pid};
      h2 = it.len[11:4];
      h3 = 8'hFF - (h0 + h1 + h2);
      crc_m = CRC_INIT;
      put_raw(FEND, 1'b0);
      put_data(h0);
      put_data(h1);
      put_data(h2);
      put_data(h3);
      open_m = 1'b1;
      left_m = it.len;
      if (it.len == 12'd0) put_close();
    end else if (open_m) begin
      put_data(it.data);
      left_m = left_m - 12'd1;
      if (left_m == 12'd0) put_close();
    end
    if (burst_q.size() != 0) burst_q[burst_q.size() - 1].last = 1'b1;
  endfunction

  function automatic link_item_t hdr(input logic [2:0] seq, input logic [2:0] ack,
                                     input logic crcf, input logic rel,
                                     input logic [3:0] pid, input logic [11:0] len);
    link_item_t it;
    it      = '0;
    it.cmd  = CMD_HEADER;
    it.seq  = seq;
    it.ack  = ack;
    it.crcf = crcf;
    it.rel  = rel;
    it.pid  = pid;
    it.len  = len;
    it.data = 8'hA5;
    return it;
  endfunction

  function automatic link_item_t pay(input logic [7:0] data);
    link_item_t it;
    it      = '0;
    it.cmd  = CMD_PAYLOAD;
    it.data = data;
    return it;
  endfunction

  function automatic link_item_t rand_item(input logic cmd);
    link_item_t it;
    it.cmd  = cmd;
    it.seq  = 3'($urandom_range(0, 7));
    it.ack  = 3'($urandom_range(0, 7));
    it.crcf = 1'($urandom_range(0, 1));
    it.rel  = 1'($urandom_range(0, 1));
    it.pid  = 4'($urandom_range(0, 15));
    it.len  = 12'($urandom_range(0, 4095));
    // lean towards the two bytes that need escaping
    if ($urandom_range(0, 5) == 0) it.data = $urandom_range(0, 1) ? FEND : FESC;
    else it.data = 8'($urandom_range(0, 255));
    return it;
  endfunction

  function automatic dir_row_t item_row(input link_item_t it);
    dir_row_t r;
    r    = '0;
    r.it = it;
    return r;
  endfunction

  function automatic dir_row_t typed_row(input link_item_t it, input logic [2:0] n,
                                         input logic [0:5][7:0] tb, input logic cl);
    dir_row_t r;
    r        = item_row(it);
    r.typed  = 1'b1;
    r.tn     = n;
    r.tb     = tb;
    r.tclose = cl;
    return r;
  endfunction

  function automatic dir_row_t cfg_row(input logic v);
    dir_row_t r;
    r         = '0;
    r.is_cfg  = 1'b1;
    r.cfg_val = v;
    return r;
  endfunction

  // Drive one item, hold it until the transfer, then queue its line bytes
  task automatic send_item(input dir_row_t row);
    line_byte_t lb;
    int         i;
    @(negedge clk);
    while ($urandom_range(0, 99) < snd_idle) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_command     = row.it.cmd;
    in_seq_num     = row.it.seq;
    in_ack_num     = row.it.ack;
    in_crc_flag    = row.it.crcf;
    in_reliable    = row.it.rel;
    in_protocol_id = row.it.pid;
    in_payload_len = row.it.len;
    in_data_byte   = row.it.data;
    in_valid       = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    frame_item(row.it);
    if (burst_q.size() == 0) n_ignored++;
    else n_items++;
    if (row.typed) begin
      burst_q.delete();
      for (i = 0; i < int'(row.tn); i++) begin
        lb.b    = row.tb[i];
        lb.last = (i == int'(row.tn) - 1);
        lb.fe   = row.tclose && lb.last;
        burst_q.push_back(lb);
      end
    end
    for (i = 0; i < burst_q.size(); i++) line_q.push_back(burst_q[i]);
  endtask

  // Drop valid, drain every owed byte, then let an ignored item work through
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (line_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_crc_enable(input logic v);
    settle();
    @(negedge clk);
    cfg_wdata = v;
    cfg_we    = 1'b1;
    @(negedge clk);
    cfg_we   = 1'b0;
    crc_en_m = v;
    n_cfg++;
  endtask

  // Mostly well-formed frames, with abandoned frames and stray payload mixed in
  task automatic run_random(input int snd, input int rcv, input logic crc_v);
    int         goal;
    int         r;
    int         n;
    link_item_t it;
    snd_idle = snd;
    rcv_idle = rcv;
    write_crc_enable(crc_v);
    goal = n_items + ITEMS_PER_PHASE;
    while (n_items < goal) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        send_item(item_row(rand_item(CMD_PAYLOAD)));
      end else begin
        it = rand_item(CMD_HEADER);
        if (r < 18) begin
          n = $urandom_range(0, 3);
        end else begin
          if ($urandom_range(0, 9) == 0) it.len = 12'($urandom_range(10, 40));
          else it.len = 12'($urandom_range(0, 9));
          n = int'(it.len);
        end
        send_item(item_row(it));
        repeat (n) send_item(item_row(rand_item(CMD_PAYLOAD)));
        if ($urandom_range(0, 29) == 0) settle();
      end
    end
  endtask

  initial begin
    // payload with no frame open goes nowhere
    plan_q.push_back(typed_row(pay(8'h5A), 3'd0, '0, 1'b0));
    // all-zero header, empty frame
    plan_q.push_back(typed_row(hdr(3'd0, 3'd0, 1'b0, 1'b0, 4'h0, 12'h000), 3'd6,
                               {8'hC0, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hC0}, 1'b1));
    // all-ones header, longest frame left open
    plan_q.push_back(typed_row(hdr(3'd7, 3'd7, 1'b1, 1'b1, 4'hF, 12'hFFF), 3'd5,
                               {8'hC0, 8'hFF, 8'hFF, 8'hFF, 8'h02, 8'h00}, 1'b0));
    plan_q.push_back(item_row(pay(8'hFF)));
    // header byte 0 equal to the delimiter, escaped payload bytes
    plan_q.push_back(item_row(hdr(3'd0, 3'd0, 1'b1, 1'b1, 4'h0, 12'h002)));
    plan_q.push_back(item_row(pay(FEND)));
    plan_q.push_back(item_row(pay(FESC)));
    // header byte 1 equal to the escape, then abandon the frame
    plan_q.push_back(item_row(hdr(3'd5, 3'd2, 1'b0, 1'b0, 4'hB, 12'h00D)));
    plan_q.push_back(item_row(pay(8'h00)));
    plan_q.push_back(cfg_row(1'b1));
    plan_q.push_back(item_row(hdr(3'd3, 3'd6, 1'b0, 1'b1, 4'h7, 12'h000)));
    plan_q.push_back(item_row(hdr(3'd1, 3'd4, 1'b0, 1'b0, 4'h2, 12'h003)));
    plan_q.push_back(item_row(pay(8'h00)));
    plan_q.push_back(item_row(pay(8'hFF)));
    plan_q.push_back(item_row(pay(8'h80)));
    // header crc bit alone adds no trailer
    plan_q.push_back(cfg_row(1'b0));
    plan_q.push_back(item_row(hdr(3'd2, 3'd1, 1'b1, 1'b0, 4'h9, 12'h001)));
    plan_q.push_back(item_row(pay(8'h55)));
    // register set while the frame is open: trailer at close only
    plan_q.push_back(item_row(hdr(3'd6, 3'd5, 1'b0, 1'b1, 4'h4, 12'h002)));
    plan_q.push_back(item_row(pay(8'hAA)));
    plan_q.push_back(cfg_row(1'b1));
    plan_q.push_back(item_row(pay(8'h5A)));

    // Hold reset, then release on a falling edge
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    snd_idle = 10;
    rcv_idle = 30;
    foreach (plan_q[k]) begin
      if (plan_q[k].is_cfg) write_crc_enable(plan_q[k].cfg_val);
      else send_item(plan_q[k]);
    end

    run_random(23, 70, 1'b1);
    run_random(70, 23, 1'b0);
    run_random(0, 0, 1'b1);

    settle();
    $display("Covered %0d framed input transfers, %0d ignored, %0d line bytes checked",
             n_items, n_ignored, n_bytes);
    $display("over %0d crc_enable writes, escaping, abandoned frames and three stall mixes",
             n_cfg);
    if (errors == 0) begin
      $display("slip_packet_framer_crc16_top test passed");
    end else begin
      $display("%0d mismatches", errors);
      $display("slip_packet_framer_crc16_top test failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/spf_pkg.sv
src/spf_front.sv
src/spf_fifo.sv
src/spf_back.sv
src/slip_packet_framer_crc16_top.sv
tb/sv/slip_packet_framer_crc16_top_tb.sv
